// ===== sv/ffal_pkg.sv =====
// Shared types, codes and helpers of the free list allocator.
`default_nettype none
package ffal_pkg;

  localparam logic [31:0] NIL       = 32'hFFFF_FFFF;
  localparam logic [31:0] MIN_BLOCK = 32'd16;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [2:0] ST_ALLOC  = 3'd0;
  localparam logic [2:0] ST_ZERO   = 3'd1;
  localparam logic [2:0] ST_BIG    = 3'd2;
  localparam logic [2:0] ST_NOFIT  = 3'd3;
  localparam logic [2:0] ST_FREED  = 3'd4;
  localparam logic [2:0] ST_IGNORE = 3'd5;

  localparam logic REG_HEAP_BYTES = 1'b0;
  localparam logic [12:0] HEAP_BYTES_RESET = 13'd4096;

  typedef struct packed {
    logic [11:0] addr;
    logic [2:0]  status;
  } result_t;

  // Magnitude of a boundary tag; negative tags mark free blocks.
  function automatic logic [31:0] mag(input logic [31:0] w);
    return w[31] ? (32'd0 - w) : w;
  endfunction

endpackage
`default_nettype wire

// ===== sv/first_fit_free_list_allocator.sv =====
// Top level of the first-fit free list allocator: register port, tag memory, sequencer.
`default_nettype none
// First-fit heap allocator with boundary tags and an explicit free list, all
// kept in one word memory of HEAP_WORDS entries (one read and one write per
// cycle, read data registered). One item is worked at a time. An allocate
// walks the free list from its head and tests each node; a fit is either
// split, or handed out whole and unlinked. A free walks the heap from word 0
// to the freed header, tags the block free and pushes it on the list, then
// looks at both neighbors and merges it with each free one before the result
// is posted. After reset and after every heap_bytes write the heap is
// reformatted as one free block, during which no item is taken. A finished
// result sits in an output register, so the next item can be taken while
// it waits.
module first_fit_free_list_allocator #(
  parameter int HEAP_WORDS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        func,
  input  wire logic [11:0] req_bytes,
  input  wire logic [11:0] free_addr,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [11:0] addr,
  output logic      [2:0]  status,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int AW = (HEAP_WORDS > 1) ? $clog2(HEAP_WORDS) : 1;
  localparam int NW = AW + 1;

  logic [12:0]   heap_bytes;
  logic [31:0]   hb_clamp;
  logic [NW-1:0] n_words;
  logic          wr_hit;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata, mem_rdata;
  ffal_pkg::result_t out_res;

  // Register port: pready always high, one register at byte 0.
  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == ffal_pkg::REG_HEAP_BYTES);
  assign prdata = (paddr[2] == ffal_pkg::REG_HEAP_BYTES) ? 32'(heap_bytes) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_bytes <= ffal_pkg::HEAP_BYTES_RESET;
    end else if (wr_hit) begin
      heap_bytes <= pwdata[12:0];
    end
  end

  // Clamp the heap size to the memory and the minimum block, word aligned.
  always_comb begin
    hb_clamp = 32'(heap_bytes);
    if (hb_clamp > 32'(4 * HEAP_WORDS)) begin
      hb_clamp = 32'(4 * HEAP_WORDS);
    end
    if (hb_clamp < ffal_pkg::MIN_BLOCK) begin
      hb_clamp = ffal_pkg::MIN_BLOCK;
    end
  end

  assign n_words = hb_clamp[NW+1:2];

  ffal_ram #(.WIDTH(32), .DEPTH(HEAP_WORDS)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Reformat the heap when the size register is written.
  ffal_ctrl #(.HEAP_WORDS(HEAP_WORDS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .fmt_start (wr_hit),
    .n_words   (n_words),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .req_bytes (req_bytes),
    .free_addr (free_addr),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  assign addr   = out_res.addr;
  assign status = out_res.status;

endmodule
`default_nettype wire

// ===== sv/ffal_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none
module ffal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/ffal_ctrl.sv =====
// Sequencer that walks and edits the heap through the tag memory.
`default_nettype none
module ffal_ctrl #(
  parameter int HEAP_WORDS = 1024,
  localparam int AW = (HEAP_WORDS > 1) ? $clog2(HEAP_WORDS) : 1,
  localparam int NW = AW + 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fmt_start,
  input  wire logic [NW-1:0]     n_words,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              func,
  input  wire logic [11:0]       req_bytes,
  input  wire logic [11:0]       free_addr,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ffal_pkg::result_t      out_res,
  output logic                   mem_we,
  output logic      [AW-1:0]     mem_waddr,
  output logic      [31:0]       mem_wdata,
  output logic      [AW-1:0]     mem_raddr,
  input  wire logic [31:0]       mem_rdata
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DONE  = 5'd1;
  localparam logic [4:0] S_FMT0  = 5'd2;
  localparam logic [4:0] S_FMT1  = 5'd3;
  localparam logic [4:0] S_FMT2  = 5'd4;
  localparam logic [4:0] S_FMT3  = 5'd5;
  localparam logic [4:0] S_A_HDR = 5'd6;
  localparam logic [4:0] S_A_NXT = 5'd7;
  localparam logic [4:0] S_A_WF  = 5'd8;
  localparam logic [4:0] S_SP2   = 5'd9;
  localparam logic [4:0] S_SP3   = 5'd10;
  localparam logic [4:0] S_SP4   = 5'd11;
  localparam logic [4:0] S_U_RP  = 5'd12;
  localparam logic [4:0] S_U_RN  = 5'd13;
  localparam logic [4:0] S_U_GO  = 5'd14;
  localparam logic [4:0] S_U_W2  = 5'd15;
  localparam logic [4:0] S_F_WLK = 5'd16;
  localparam logic [4:0] S_F_FT  = 5'd17;
  localparam logic [4:0] S_F_P1  = 5'd18;
  localparam logic [4:0] S_F_P2  = 5'd19;
  localparam logic [4:0] S_F_P3  = 5'd20;
  localparam logic [4:0] S_F_RR  = 5'd21;
  localparam logic [4:0] S_F_LR  = 5'd22;
  localparam logic [4:0] S_F_LC  = 5'd23;
  localparam logic [4:0] S_M_RH  = 5'd24;
  localparam logic [4:0] S_M_H   = 5'd25;
  localparam logic [4:0] S_M_R   = 5'd26;
  localparam logic [4:0] S_M_W1  = 5'd27;
  localparam logic [4:0] S_M_W2  = 5'd28;

  logic [4:0]    state, state_next, ret, ret_next, mret, mret_next;
  logic          mchk, mchk_next, hv, hv_next, out_valid_next;
  logic [AW-1:0] t, t_next, h, h_next, target, target_next;
  logic [AW-1:0] mh, mh_next, mr, mr_next, ut, ut_next;
  logic [AW-1:0] fh, fh_next, nxt, nxt_next;
  logic [31:0]   prev, prev_next, sz, sz_next, mhs, mhs_next, msum, msum_next;
  logic [12:0]   need, need_next;
  ffal_pkg::result_t res, res_next, out_res_next;

  logic [31:0] tsz, rem, bs, sum, ls, nbytes, need32;
  logic [12:0] rnd;
  logic [11:0] tgt;
  logic [AW-1:0] nb;

  function automatic logic [AW-1:0] ix(input logic [31:0] v);
    return v[AW-1:0];
  endfunction

  assign nbytes = 32'({n_words, 2'b00});
  assign need32 = 32'(need);
  assign tsz    = ffal_pkg::mag(mem_rdata);
  assign rem    = tsz - need32;
  assign bs     = ffal_pkg::mag(mem_rdata);
  assign sum    = 32'(h) + (bs >> 2);
  assign ls     = ffal_pkg::mag(mem_rdata) >> 2;
  assign rnd    = (13'(req_bytes) + 13'd3) & ~13'd3;
  assign tgt    = {2'b00, free_addr[11:2]} - 12'd1;
  assign nb     = ix(32'(t) + (sz >> 2));

  always_comb begin
    state_next = state; ret_next = ret; mret_next = mret; mchk_next = mchk;
    hv_next = hv; t_next = t; h_next = h; target_next = target; mh_next = mh;
    mr_next = mr; ut_next = ut; fh_next = fh; nxt_next = nxt; prev_next = prev;
    sz_next = sz; mhs_next = mhs; msum_next = msum; need_next = need;
    res_next = res; out_res_next = out_res;
    out_valid_next = out_valid;
    in_ready = 1'b0;
    mem_we = 1'b0; mem_waddr = '0; mem_wdata = '0; mem_raddr = '0;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (func == ffal_pkg::FUNC_ALLOC) begin
            res_next = '{addr: 12'd0, status: ffal_pkg::ST_ALLOC};
            need_next = ((rnd < 13'd8) ? 13'd8 : rnd) + 13'd8;
            if (req_bytes == 12'd0) begin
              res_next.status = ffal_pkg::ST_ZERO; state_next = S_DONE;
            end else if (32'(req_bytes) > nbytes - 32'd8) begin
              res_next.status = ffal_pkg::ST_BIG; state_next = S_DONE;
            end else if (!hv) begin
              res_next.status = ffal_pkg::ST_NOFIT; state_next = S_DONE;
            end else begin
              t_next = fh; mem_raddr = fh; state_next = S_A_HDR;
            end
          end else begin
            res_next = '{addr: 12'd0, status: ffal_pkg::ST_IGNORE};
            if (free_addr[1:0] != 2'b00 || free_addr < 12'd4 ||
                32'(tgt) >= 32'(n_words)) begin
              state_next = S_DONE;
            end else begin
              target_next = ix(32'(tgt)); h_next = '0; mem_raddr = '0;
              state_next = S_F_WLK;
            end
          end
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1; out_res_next = res; state_next = S_IDLE;
        end
      end
      S_FMT0: begin
        mem_we = 1'b1; mem_waddr = '0; mem_wdata = 32'd0 - nbytes;
        state_next = S_FMT1;
      end
      S_FMT1: begin
        mem_we = 1'b1; mem_waddr = ix(32'(n_words) - 32'd1);
        mem_wdata = 32'd0 - nbytes; state_next = S_FMT2;
      end
      S_FMT2: begin
        mem_we = 1'b1; mem_waddr = ix(32'd1); mem_wdata = ffal_pkg::NIL;
        state_next = S_FMT3;
      end
      S_FMT3: begin
        mem_we = 1'b1; mem_waddr = ix(32'd2); mem_wdata = ffal_pkg::NIL;
        fh_next = '0; hv_next = 1'b1; state_next = S_IDLE;
      end
      S_A_HDR: begin
        if (need32 <= tsz) begin
          mem_we = 1'b1; mem_waddr = t;
          if (rem < ffal_pkg::MIN_BLOCK) begin
            mem_wdata = tsz; sz_next = tsz;
            res_next.addr = 12'((32'(t) + 32'd1) << 2);
            state_next = S_A_WF;
          end else begin
            mem_wdata = 32'd0 - rem; sz_next = rem; state_next = S_SP2;
          end
        end else begin
          mem_raddr = ix(32'(t) + 32'd2); state_next = S_A_NXT;
        end
      end
      S_A_NXT: begin
        if (mem_rdata == ffal_pkg::NIL || mem_rdata >= 32'(n_words)) begin
          res_next.status = ffal_pkg::ST_NOFIT; state_next = S_DONE;
        end else begin
          t_next = ix(mem_rdata); mem_raddr = ix(mem_rdata);
          state_next = S_A_HDR;
        end
      end
      S_A_WF: begin
        mem_we = 1'b1; mem_waddr = ix(32'(t) + (sz >> 2) - 32'd1);
        mem_wdata = sz; ut_next = t; ret_next = S_DONE; state_next = S_U_RP;
      end
      S_SP2: begin
        mem_we = 1'b1; mem_waddr = ix(32'(t) + (sz >> 2) - 32'd1);
        mem_wdata = 32'd0 - sz; state_next = S_SP3;
      end
      S_SP3: begin
        mem_we = 1'b1; mem_waddr = nb; mem_wdata = need32; state_next = S_SP4;
      end
      S_SP4: begin
        mem_we = 1'b1; mem_waddr = ix(32'(nb) + (need32 >> 2) - 32'd1);
        mem_wdata = need32;
        res_next.addr = 12'((32'(nb) + 32'd1) << 2); state_next = S_DONE;
      end
      S_U_RP: begin
        mem_raddr = ix(32'(ut) + 32'd1); state_next = S_U_RN;
      end
      S_U_RN: begin
        prev_next = mem_rdata; mem_raddr = ix(32'(ut) + 32'd2);
        state_next = S_U_GO;
      end
      S_U_GO: begin
        state_next = ret;
        if (prev == ffal_pkg::NIL) begin
          if (mem_rdata == ffal_pkg::NIL) begin
            hv_next = 1'b0;
          end else begin
            fh_next = ix(mem_rdata); hv_next = 1'b1;
            mem_we = 1'b1; mem_waddr = ix(mem_rdata + 32'd1);
            mem_wdata = ffal_pkg::NIL;
          end
        end else begin
          mem_we = 1'b1; mem_waddr = ix(prev + 32'd2); mem_wdata = mem_rdata;
          if (mem_rdata != ffal_pkg::NIL) begin
            nxt_next = ix(mem_rdata); state_next = S_U_W2;
          end
        end
      end
      S_U_W2: begin
        mem_we = 1'b1; mem_waddr = ix(32'(nxt) + 32'd1); mem_wdata = prev;
        state_next = ret;
      end
      S_F_WLK: begin
        if (h < target) begin
          if (bs < 32'd4 || bs[1:0] != 2'b00 || sum > 32'(target)) begin
            state_next = S_DONE;
          end else begin
            h_next = ix(sum); mem_raddr = ix(sum);
          end
        end else if (mem_rdata[31] || mem_rdata < ffal_pkg::MIN_BLOCK ||
                     mem_rdata[1:0] != 2'b00 ||
                     32'(h) + (mem_rdata >> 2) > 32'(n_words)) begin
          state_next = S_DONE;
        end else begin
          mem_we = 1'b1; mem_waddr = h; mem_wdata = 32'd0 - mem_rdata;
          sz_next = mem_rdata; state_next = S_F_FT;
        end
      end
      S_F_FT: begin
        mem_we = 1'b1; mem_waddr = ix(32'(h) + (sz >> 2) - 32'd1);
        mem_wdata = 32'd0 - sz; state_next = S_F_P1;
      end
      S_F_P1: begin
        mem_we = 1'b1; mem_waddr = ix(32'(h) + 32'd1);
        mem_wdata = ffal_pkg::NIL; state_next = S_F_P2;
      end
      S_F_P2: begin
        mem_we = 1'b1; mem_waddr = ix(32'(h) + 32'd2);
        mem_wdata = hv ? 32'(fh) : ffal_pkg::NIL;
        if (hv) begin
          state_next = S_F_P3;
        end else begin
          fh_next = h; hv_next = 1'b1; state_next = S_F_RR;
        end
      end
      S_F_P3: begin
        mem_we = 1'b1; mem_waddr = ix(32'(fh) + 32'd1); mem_wdata = 32'(h);
        fh_next = h; state_next = S_F_RR;
      end
      S_F_RR: begin
        if (32'(h) + (sz >> 2) < 32'(n_words)) begin
          mh_next = h; mchk_next = 1'b1; mret_next = S_F_LR;
          state_next = S_M_RH;
        end else begin
          state_next = S_F_LR;
        end
      end
      S_F_LR: begin
        res_next = '{addr: 12'd0, status: ffal_pkg::ST_FREED};
        if (h != '0) begin
          mem_raddr = ix(32'(h) - 32'd1); state_next = S_F_LC;
        end else begin
          state_next = S_DONE;
        end
      end
      S_F_LC: begin
        state_next = S_DONE;
        if (mem_rdata[31] && ls >= 32'd1 && ls <= 32'(h)) begin
          mh_next = ix(32'(h) - ls); mchk_next = 1'b0; mret_next = S_DONE;
          state_next = S_M_RH;
        end
      end
      S_M_RH: begin
        mem_raddr = mh; state_next = S_M_H;
      end
      S_M_H: begin
        mhs_next = bs; mr_next = ix(32'(mh) + (bs >> 2));
        mem_raddr = ix(32'(mh) + (bs >> 2)); state_next = S_M_R;
      end
      S_M_R: begin
        if (mchk && !mem_rdata[31]) begin
          state_next = mret;
        end else begin
          msum_next = mhs + bs; ut_next = mr; ret_next = S_M_W1;
          state_next = S_U_RP;
        end
      end
      S_M_W1: begin
        mem_we = 1'b1; mem_waddr = mh; mem_wdata = 32'd0 - msum;
        state_next = S_M_W2;
      end
      S_M_W2: begin
        mem_we = 1'b1; mem_waddr = ix(32'(mh) + (msum >> 2) - 32'd1);
        mem_wdata = 32'd0 - msum; state_next = mret;
      end
      default: state_next = S_IDLE;
    endcase
    if (fmt_start) begin
      state_next = S_FMT0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FMT0;
      hv <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      hv <= hv_next;
      out_valid <= out_valid_next;
    end
    ret <= ret_next; mret <= mret_next; mchk <= mchk_next;
    t <= t_next; h <= h_next; target <= target_next; mh <= mh_next;
    mr <= mr_next; ut <= ut_next; fh <= fh_next; nxt <= nxt_next;
    prev <= prev_next; sz <= sz_next; mhs <= mhs_next; msum <= msum_next;
    need <= need_next; res <= res_next; out_res <= out_res_next;
  end

endmodule
`default_nettype wire

// ===== verif/ffal_checker.sv =====
// Checker of the free list allocator: heap predictor, result store and comparison.
`timescale 1ns / 100ps
module ffal_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic        func,
  input  wire logic [11:0] req_bytes,
  input  wire logic [11:0] free_addr,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [11:0] addr,
  input  wire logic [2:0]  status,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               fail_count,
  output int               pending
);

  localparam int WORDS = 1024;

  logic [31:0] tag_mem [WORDS];
  logic [31:0] list_head;
  bit          list_ok;
  logic [31:0] heap_words_used;
  logic [12:0] heap_size_reg;
  ffal_pkg::result_t awaited_q [$];

  function automatic logic [31:0] rd(input logic [31:0] i);
    return (i < WORDS) ? tag_mem[i] : 32'd0;
  endfunction

  function automatic void wr(input logic [31:0] i, input logic [31:0] v);
    if (i < WORDS) tag_mem[i] = v;
  endfunction

  function automatic logic [31:0] size_of(input logic [31:0] w);
    return w[31] ? (32'd0 - w) : w;
  endfunction

  function automatic void tag_block(input logic [31:0] h, input logic [31:0] sz, input bit fr);
    logic [31:0] code;
    code = fr ? (32'd0 - sz) : sz;
    wr(h, code);
    if (sz >= 4) wr(h + sz / 4 - 1, code);
  endfunction

  function automatic void unlink(input logic [31:0] t);
    logic [31:0] pv, nx;
    pv = rd(t + 1);
    nx = rd(t + 2);
    if (pv == ffal_pkg::NIL) begin
      if (nx == ffal_pkg::NIL) list_ok = 0;
      else begin
        list_head = nx;
        list_ok = 1;
        wr(nx + 1, ffal_pkg::NIL);
      end
    end else begin
      wr(pv + 2, nx);
      if (nx != ffal_pkg::NIL) wr(nx + 1, pv);
    end
  endfunction

  function automatic void push_front(input logic [31:0] t);
    wr(t + 1, ffal_pkg::NIL);
    wr(t + 2, list_ok ? list_head : ffal_pkg::NIL);
    if (list_ok) wr(list_head + 1, t);
    list_head = t;
    list_ok = 1;
  endfunction

  function automatic void absorb_right(input logic [31:0] h);
    logic [31:0] hs, r, rs;
    hs = size_of(rd(h));
    r  = h + hs / 4;
    rs = size_of(rd(r));
    unlink(r);
    tag_block(h, hs + rs, 1);
  endfunction

  function automatic void reformat(input logic [12:0] bytes);
    logic [31:0] b;
    b = bytes;
    if (b > 4 * WORDS) b = 4 * WORDS;
    if (b < ffal_pkg::MIN_BLOCK) b = ffal_pkg::MIN_BLOCK;
    b = b & ~32'd3;
    heap_words_used = b / 4;
    for (int i = 0; i < WORDS; i++) tag_mem[i] = 32'd0;
    tag_block(0, b, 1);
    wr(1, ffal_pkg::NIL);
    wr(2, ffal_pkg::NIL);
    list_head = 0;
    list_ok = 1;
  endfunction

  function automatic ffal_pkg::result_t carve(input logic [31:0] req);
    ffal_pkg::result_t r;
    logic [31:0] asz, t, tsz, rem, nb;
    r.addr = '0;
    r.status = ffal_pkg::ST_NOFIT;
    if (req == 0) begin
      r.status = ffal_pkg::ST_ZERO;
      return r;
    end
    if (req > heap_words_used * 4 - 8) begin
      r.status = ffal_pkg::ST_BIG;
      return r;
    end
    asz = (req + 3) & ~32'd3;
    if (asz < 8) asz = 8;
    if (!list_ok) return r;
    t = list_head;
    for (int n = 0; n < heap_words_used && t < heap_words_used; n++) begin
      tsz = size_of(rd(t));
      if (asz + 8 <= tsz) begin
        rem = tsz - asz - 8;
        if (rem < ffal_pkg::MIN_BLOCK) begin
          tag_block(t, tsz, 0);
          unlink(t);
          r.addr = 12'((t + 1) * 4);
        end else begin
          nb = t + rem / 4;
          tag_block(t, rem, 1);
          tag_block(nb, asz + 8, 0);
          r.addr = 12'((nb + 1) * 4);
        end
        r.status = ffal_pkg::ST_ALLOC;
        return r;
      end
      t = rd(t + 2);
      if (t == ffal_pkg::NIL) break;
    end
    return r;
  endfunction

  function automatic logic [2:0] release_block(input logic [31:0] fa);
    logic [31:0] target, h, s, bs, f, ls;
    if (fa[1:0] != 0 || fa < 4) return ffal_pkg::ST_IGNORE;
    target = fa / 4 - 1;
    if (target >= heap_words_used) return ffal_pkg::ST_IGNORE;
    h = 0;
    while (h < target) begin
      bs = size_of(rd(h));
      if (bs < 4 || bs[1:0] != 0) return ffal_pkg::ST_IGNORE;
      h = h + bs / 4;
    end
    if (h != target) return ffal_pkg::ST_IGNORE;
    if (rd(h) >> 31) return ffal_pkg::ST_IGNORE;
    s = rd(h);
    if (s < ffal_pkg::MIN_BLOCK || s[1:0] != 0 || h + s / 4 > heap_words_used) begin
      return ffal_pkg::ST_IGNORE;
    end
    tag_block(h, s, 1);
    push_front(h);
    if (h + s / 4 < heap_words_used && (rd(h + s / 4) >> 31)) absorb_right(h);
    if (h > 0) begin
      f = rd(h - 1);
      if (f >> 31) begin
        ls = size_of(f) / 4;
        if (ls >= 1 && ls <= h) absorb_right(h - ls);
      end
    end
    return ffal_pkg::ST_FREED;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    heap_size_reg = ffal_pkg::HEAP_BYTES_RESET;
    reformat(ffal_pkg::HEAP_BYTES_RESET);
  end

  assign pending = awaited_q.size();

  always @(posedge clk) begin
    ffal_pkg::result_t want, nxt;
    if (rst) begin
      awaited_q.delete();
      heap_size_reg = ffal_pkg::HEAP_BYTES_RESET;
      reformat(heap_size_reg);
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_q.size() == 0) begin
          report("unexpected result status", 32'(status), 32'd0);
        end else begin
          want = awaited_q.pop_front();
          if (addr != want.addr) report("addr", addr, want.addr);
          if (status != want.status) report("status", status, want.status);
        end
      end
      if (psel && penable && pwrite && pready && paddr[2] == ffal_pkg::REG_HEAP_BYTES) begin
        heap_size_reg = pwdata[12:0];
        reformat(heap_size_reg);
      end
      if (in_valid && in_ready) begin
        nxt.addr = '0;
        if (func == ffal_pkg::FUNC_ALLOC) nxt = carve({20'd0, req_bytes});
        else nxt.status = release_block({20'd0, free_addr});
        awaited_q.push_back(nxt);
      end
    end
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the allocator testbench: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 100ps
module testbench;

  localparam int IDLE_LIMIT = 20000;
  localparam int ITEMS_PER_PHASE = 128;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic        func = ffal_pkg::FUNC_ALLOC;
  logic [11:0] req_bytes = '0;
  logic [11:0] free_addr = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [11:0] addr;
  logic [2:0]  status;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  int burst_left = 0;
  int heap_now = 4096;

  // Payload addresses handed out and not yet sent back, and ones already freed.
  logic [11:0] live_q [$];
  logic [11:0] freed_q [$];

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  first_fit_free_list_allocator dut (.*);

  ffal_checker chk (.*);

  // Receiver: stall on a pattern that changes mode at random intervals.
  int rx_mode = 0;
  int rx_count = 0;
  int rx_stall = 0;
  always @(posedge clk) begin
    if (rx_count == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_count <= $urandom_range(50, 300);
    end else rx_count <= rx_count - 1;
    case (rx_mode)
      0: out_ready <= 1;
      1: out_ready <= $urandom_range(0, 1);
      default: begin
        if (rx_stall > 0) begin
          rx_stall <= rx_stall - 1;
          out_ready <= 0;
        end else begin
          out_ready <= 1;
          if ($urandom_range(0, 7) == 0) rx_stall <= $urandom_range(1, 30);
        end
      end
    endcase
  end

  // Track granted addresses so frees can target real blocks.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready && status == ffal_pkg::ST_ALLOC) live_q.push_back(addr);
  end

  // Watchdog: count cycles in which nothing moves on any port.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Send one item; may pause between bursts, otherwise keep valid high back to back.
  task automatic send(input logic f, input logic [11:0] rq, input logic [11:0] fa);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1;
    func <= f;
    req_bytes <= rq;
    free_addr <= fa;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_alloc(input int n);
    send(ffal_pkg::FUNC_ALLOC, 12'(n), 12'($urandom_range(0, 4095)));
  endtask

  task automatic send_free(input logic [11:0] fa);
    send(ffal_pkg::FUNC_FREE, 12'($urandom_range(0, 4095)), fa);
  endtask

  // Drop valid and hold until every expected result has come back.
  task automatic drain();
    in_valid <= 0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic free_live(input int idx);
    logic [11:0] a;
    if (idx < live_q.size()) begin
      a = live_q[idx];
      live_q.delete(idx);
      freed_q.push_back(a);
      send_free(a);
    end
  endtask

  // Write the heap size over the register port: setup cycle, then access cycle.
  task automatic set_heap(input int bytes);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= 3'({ffal_pkg::REG_HEAP_BYTES, 2'b00});
    pwdata <= 32'(bytes);
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    live_q.delete();
    freed_q.delete();
    heap_now = (bytes & 13'h1FFF) > 4096 ? 4096 : ((bytes & 13'h1FFF) < 16 ? 16 : bytes);
    heap_now = heap_now & ~3;
    repeat (6) @(posedge clk);
  endtask

  // Random item: mostly allocate and free of live blocks, the rest noise.
  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50 || (r < 85 && live_q.size() == 0)) begin
      r = $urandom_range(0, 99);
      if (r < 70) send_alloc($urandom_range(1, 64));
      else if (r < 90) send_alloc($urandom_range(1, heap_now / 4));
      else if (r < 97) send_alloc($urandom_range(0, 4095));
      else send_alloc(0);
    end else if (r < 85) begin
      free_live($urandom_range(0, live_q.size() - 1));
    end else if (r < 92 && freed_q.size() != 0) begin
      send_free(freed_q[$urandom_range(0, freed_q.size() - 1)]);
    end else begin
      send_free(12'($urandom_range(0, 4095)));
    end
  endtask

  int settings [7] = '{16, 8191, 100, 5, 4097, 1000, 4096};

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    repeat (6) @(posedge clk);

    // Directed: zero size, too large, exact whole-heap fit, no fit, frees of all kinds.
    send_alloc(0);
    send_alloc(4089);
    send_alloc(4095);
    send_alloc(4088);
    send_alloc(1);
    send_free(12'd4);
    send_free(12'd4);
    send_free(12'd0);
    send_free(12'd2);
    send_free(12'd4095);
    send_free(12'd8);
    send_alloc(1);
    send_alloc(8);
    send_alloc(9);
    send_alloc(100);
    send_alloc(4000);
    drain();
    // Free out of order so blocks merge right, left and both ways.
    free_live(1);
    free_live(1);
    free_live(0);
    free_live(0);
    send_alloc(2048);
    send_alloc(4084);
    drain();

    for (int i = 0; i < ITEMS_PER_PHASE; i++) random_item();
    drain();
    foreach (settings[k]) begin
      set_heap(settings[k]);
      if (k == 0) begin
        // Smallest heap: one block holds just an 8 byte payload.
        send_alloc(8);
        send_alloc(1);
        send_alloc(9);
        drain();
        free_live(0);
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) random_item();
      drain();
    end

    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
